// File: hdl/rc4_pkg.sv
// shared types and constants for the rc4 cipher engine
// sizes, controller states, datapath operations and the command/status structs
// no dependencies
package rc4_pkg;

  localparam int BYTE_W        = 8;
  localparam int PERM_DEPTH    = 256;
  localparam int PERM_AW       = 8;
  localparam int MAX_KEY_BYTES = 256;
  localparam int KEY_AW        = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
  localparam int KEY_CW        = $clog2(MAX_KEY_BYTES + 1);
  localparam int KEY_CW1       = KEY_CW + 1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_KS_A,
    ST_KS_B,
    ST_KS_C,
    ST_KS_D,
    ST_DT_B,
    ST_DT_C,
    ST_DT_D
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_KEY_LOAD,
    OP_KS_A,
    OP_KS_B,
    OP_KS_C,
    OP_KS_D,
    OP_DT_A,
    OP_DT_B,
    OP_DT_C,
    OP_DT_D
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   out_load;
  } cmd_t;

  typedef struct packed {
    logic round_last;
    logic out_free;
  } sts_t;

endpackage

// File: hdl/rc4_ram.sv
// generic single write port, single read port ram with registered read
// old data is returned when a location is read and written in the same cycle
// no dependencies
module rc4_ram #(
  parameter  int WIDTH = 8,
  parameter  int DEPTH = 256,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hdl/rc4_dp.sv
// rc4 datapath: permutation ram with per-entry valid bits, key store ram,
// stream indices, key schedule counters and the result register
// depends on rc4_pkg and rc4_ram
module rc4_dp (
  input  logic                       clk,
  input  logic                       rst_n,
  input  rc4_pkg::cmd_t              cmd,
  output rc4_pkg::sts_t              sts,
  input  logic [rc4_pkg::BYTE_W-1:0] in_byte_value,
  input  logic                       in_key_last,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [rc4_pkg::BYTE_W-1:0] out_byte,
  output logic [rc4_pkg::BYTE_W-1:0] out_keystream_byte
);
  import rc4_pkg::*;

  logic [PERM_DEPTH-1:0] pv_r, pv_nxt;
  logic [PERM_AW-1:0]    i_r, i_nxt, j_r, j_nxt;
  logic [PERM_AW-1:0]    n_r, n_nxt, acc_r, acc_nxt;
  logic [KEY_AW-1:0]     k_r, k_nxt;
  logic [KEY_CW-1:0]     cnt_r, cnt_nxt, len_r, len_nxt, cnt_sat;
  logic [KEY_CW1-1:0]    k_inc;
  logic [BYTE_W-1:0]     si_r, si_nxt, sj_r, sj_nxt, data_r, data_nxt;
  logic [PERM_AW-1:0]    t_r, t_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0]     obyte_r, obyte_nxt, oks_r, oks_nxt;

  logic                  p_we, p_re;
  logic [PERM_AW-1:0]    p_waddr, p_raddr;
  logic [BYTE_W-1:0]     p_wdata, p_rdata, pdata;
  logic                  prd_valid_r;
  logic [PERM_AW-1:0]    prd_addr_r;
  logic                  k_we, k_re;
  logic [BYTE_W-1:0]     kdata;
  logic [BYTE_W-1:0]     ks;
  logic                  key_room;

  rc4_ram #(.WIDTH(BYTE_W), .DEPTH(PERM_DEPTH)) u_perm (
    .clk   (clk),
    .we    (p_we),
    .waddr (p_waddr),
    .wdata (p_wdata),
    .re    (p_re),
    .raddr (p_raddr),
    .rdata (p_rdata)
  );

  rc4_ram #(.WIDTH(BYTE_W), .DEPTH(MAX_KEY_BYTES)) u_key (
    .clk   (clk),
    .we    (k_we),
    .waddr (cnt_r[KEY_AW-1:0]),
    .wdata (in_byte_value),
    .re    (k_re),
    .raddr (k_r),
    .rdata (kdata)
  );

  // entries not yet written since the last schedule read as identity
  assign pdata    = prd_valid_r ? p_rdata : prd_addr_r;
  assign ks       = (t_r == j_r) ? si_r : ((t_r == i_r) ? sj_r : pdata);
  assign key_room = cnt_r < KEY_CW'(MAX_KEY_BYTES);
  assign cnt_sat  = key_room ? cnt_r + 1'b1 : cnt_r;
  assign k_inc    = KEY_CW1'(k_r) + 1'b1;

  assign sts.round_last = (n_r == '1);
  assign sts.out_free   = !out_valid_r || !out_stall;

  always_comb begin
    pv_nxt   = pv_r;
    i_nxt    = i_r;
    j_nxt    = j_r;
    n_nxt    = n_r;
    acc_nxt  = acc_r;
    k_nxt    = k_r;
    cnt_nxt  = cnt_r;
    len_nxt  = len_r;
    si_nxt   = si_r;
    sj_nxt   = sj_r;
    data_nxt = data_r;
    t_nxt    = t_r;
    p_we     = 1'b0;
    p_re     = 1'b0;
    p_waddr  = n_r;
    p_raddr  = n_r;
    p_wdata  = si_r;
    k_we     = 1'b0;
    k_re     = 1'b0;
    unique case (cmd.op)
      OP_KEY_LOAD: begin
        k_we    = key_room;
        cnt_nxt = cnt_sat;
        if (in_key_last) begin
          cnt_nxt = '0;
          len_nxt = cnt_sat;
          pv_nxt  = '0;
          n_nxt   = '0;
          acc_nxt = '0;
          k_nxt   = '0;
          i_nxt   = '0;
          j_nxt   = '0;
        end
      end
      OP_KS_A: begin
        p_re    = 1'b1;
        p_raddr = n_r;
        k_re    = 1'b1;
      end
      OP_KS_B: begin
        si_nxt  = pdata;
        acc_nxt = acc_r + pdata + kdata;
        p_re    = 1'b1;
        p_raddr = acc_nxt;
      end
      OP_KS_C: begin
        p_we    = 1'b1;
        p_waddr = n_r;
        p_wdata = pdata;
      end
      OP_KS_D: begin
        p_we    = 1'b1;
        p_waddr = acc_r;
        p_wdata = si_r;
        n_nxt   = n_r + 1'b1;
        k_nxt   = (k_inc == KEY_CW1'(len_r)) ? '0 : k_inc[KEY_AW-1:0];
      end
      OP_DT_A: begin
        data_nxt = in_byte_value;
        i_nxt    = i_r + 1'b1;
        p_re     = 1'b1;
        p_raddr  = i_nxt;
      end
      OP_DT_B: begin
        si_nxt  = pdata;
        j_nxt   = j_r + pdata;
        p_re    = 1'b1;
        p_raddr = j_nxt;
      end
      OP_DT_C: begin
        sj_nxt  = pdata;
        p_we    = 1'b1;
        p_waddr = i_r;
        p_wdata = pdata;
        t_nxt   = si_r + pdata;
        p_re    = 1'b1;
        p_raddr = t_nxt;
      end
      OP_DT_D: begin
        p_we    = 1'b1;
        p_waddr = j_r;
        p_wdata = si_r;
      end
      OP_NONE: begin
      end
      default: begin
      end
    endcase
    if (p_we) begin
      pv_nxt[p_waddr] = 1'b1;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    obyte_nxt     = obyte_r;
    oks_nxt       = oks_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
      obyte_nxt     = data_r ^ ks;
      oks_nxt       = ks;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r        <= '0;
      i_r         <= '0;
      j_r         <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pv_r        <= pv_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r      <= n_nxt;
    acc_r    <= acc_nxt;
    k_r      <= k_nxt;
    len_r    <= len_nxt;
    si_r     <= si_nxt;
    sj_r     <= sj_nxt;
    data_r   <= data_nxt;
    t_r      <= t_nxt;
    obyte_r  <= obyte_nxt;
    oks_r    <= oks_nxt;
    if (p_re) begin
      prd_valid_r <= pv_r[p_raddr];
      prd_addr_r  <= p_raddr;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_byte           = obyte_r;
  assign out_keystream_byte = oks_r;

endmodule

// File: hdl/rc4_ctrl.sv
// rc4 controller: sequences key loads, the key schedule rounds and keystream steps
// drives datapath commands and input stall; depends on rc4_pkg
module rc4_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic          in_action,
  input  logic          in_key_last,
  input  rc4_pkg::sts_t sts,
  output rc4_pkg::cmd_t cmd
);
  import rc4_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cmd.op       = OP_NONE;
    cmd.out_load = 1'b0;
    in_stall     = (state_r != ST_IDLE);
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_action) begin
            cmd.op    = OP_DT_A;
            state_nxt = ST_DT_B;
          end else begin
            cmd.op    = OP_KEY_LOAD;
            state_nxt = in_key_last ? ST_KS_A : ST_IDLE;
          end
        end
      end
      ST_KS_A: begin
        cmd.op    = OP_KS_A;
        state_nxt = ST_KS_B;
      end
      ST_KS_B: begin
        cmd.op    = OP_KS_B;
        state_nxt = ST_KS_C;
      end
      ST_KS_C: begin
        cmd.op    = OP_KS_C;
        state_nxt = ST_KS_D;
      end
      ST_KS_D: begin
        cmd.op    = OP_KS_D;
        state_nxt = sts.round_last ? ST_IDLE : ST_KS_A;
      end
      ST_DT_B: begin
        cmd.op    = OP_DT_B;
        state_nxt = ST_DT_C;
      end
      ST_DT_C: begin
        cmd.op    = OP_DT_C;
        state_nxt = ST_DT_D;
      end
      ST_DT_D: begin
        cmd.op = OP_DT_D;
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// File: hdl/rc4_stream_cipher_top.sv
// rc4 stream cipher engine, top level
// joins the controller and the datapath; depends on rc4_pkg, rc4_ctrl, rc4_dp
//
//   channel  | ports                                      | direction
//   input    | in_valid in_stall in_action in_byte_value  | key or data item in
//            | in_key_last                                |
//   result   | out_valid out_stall out_byte               | one item per data item
//            | out_keystream_byte                         |
//
// data item: taken in idle, then runs through DT_B, DT_C and DT_D, set by three
// dependent reads of the permutation ram, each with a registered read
// key byte: stored in idle; the last key byte starts a schedule of 256 rounds,
// each through KS_A to KS_D, during which no item is accepted
// reset restores the identity permutation at once through per-entry valid bits
// a stalled result holds the engine in its last data cycle until it is taken
module rc4_stream_cipher_top (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_action,
  input  logic [rc4_pkg::BYTE_W-1:0] in_byte_value,
  input  logic                       in_key_last,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [rc4_pkg::BYTE_W-1:0] out_byte,
  output logic [rc4_pkg::BYTE_W-1:0] out_keystream_byte
);
  import rc4_pkg::*;

  cmd_t cmd;
  sts_t sts;

  rc4_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_action   (in_action),
    .in_key_last (in_key_last),
    .sts         (sts),
    .cmd         (cmd)
  );

  rc4_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_byte_value      (in_byte_value),
    .in_key_last        (in_key_last),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_byte           (out_byte),
    .out_keystream_byte (out_keystream_byte)
  );

endmodule
